// ----- rtl/char_lcd_init_refresh_controller_top_macros.svh -----
// Assertion macros used by the controller's top-level RTL.
`ifndef CHAR_LCD_INIT_REFRESH_CONTROLLER_TOP_MACROS_SVH
`define CHAR_LCD_INIT_REFRESH_CONTROLLER_TOP_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CLCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define CLCD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/clcd_pkg.sv -----
package clcd_pkg;

  // Characters per display line (default)
  localparam int LINE_CHARS = 16;

  // Register reset values
  localparam logic [7:0] POWER_UP_WAIT_RST = 8'd20;
  localparam logic [7:0] RESET_WAIT_RST    = 8'd2;
  localparam logic [7:0] CLEAR_WAIT_RST    = 8'd1;
  localparam logic [7:0] REFRESH_WAIT_RST  = 8'd50;

  // Register indexes (word address)
  localparam logic [1:0] REG_POWER_UP_WAIT = 2'd0;
  localparam logic [1:0] REG_RESET_WAIT    = 2'd1;
  localparam logic [1:0] REG_CLEAR_WAIT    = 2'd2;
  localparam logic [1:0] REG_REFRESH_WAIT  = 2'd3;

  // Item kinds
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Panel commands
  localparam logic [7:0] CMD_FUNC_SET   = 8'h30;
  localparam logic [7:0] CMD_FUNC_2LINE = 8'h38;
  localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_ENTRY      = 8'h06;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_DDRAM_L2   = 8'hC0;

  // Banner characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef enum logic [3:0] {
    PH_POWER_UP   = 4'd0,
    PH_RESET_WAIT = 4'd1,
    PH_FUNC_3     = 4'd2,
    PH_FUNC_LINES = 4'd3,
    PH_DISP_OFF   = 4'd4,
    PH_CLEAR      = 4'd5,
    PH_ENTRY      = 4'd6,
    PH_DISP_ON    = 4'd7,
    PH_IDLE       = 4'd8,
    PH_HOME       = 4'd9,
    PH_LINE1      = 4'd10,
    PH_DDRAM      = 4'd11,
    PH_LINE2      = 4'd12
  } phase_t;

  typedef struct packed {
    logic [7:0] power_up_wait;
    logic [7:0] reset_wait;
    logic [7:0] clear_wait;
    logic [7:0] refresh_wait;
  } cfg_t;

  typedef struct packed {
    logic       func;
    logic       busy_flag;
    logic       char_line;
    logic [3:0] char_column;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic       bus_write;
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       refresh_idle;
  } out_item_t;

  // Wait ends once the counter passes the limit or saturates
  function automatic logic wait_done(logic [7:0] count, logic [7:0] limit);
    return (count > limit) || (count == 8'hFF);
  endfunction

  // Saturating increment
  function automatic logic [7:0] bump(logic [7:0] count);
    return (count == 8'hFF) ? count : count + 8'd1;
  endfunction

  // Power-up contents of the line store: "Ch1=" / "Ch2=", space padded
  function automatic logic [7:0] banner_char(int addr, int line_chars);
    int   col;
    logic second;
    second = (addr >= line_chars);
    col    = second ? addr - line_chars : addr;
    case (col)
      0:       return CH_C;
      1:       return CH_H;
      2:       return second ? CH_TWO : CH_ONE;
      3:       return CH_EQ;
      default: return CH_SPACE;
    endcase
  endfunction

endpackage

// ----- rtl/clcd_line_store.sv -----
module clcd_line_store #(
  parameter int LineChars = clcd_pkg::LINE_CHARS,
  parameter int AddrW     = $clog2(2 * LineChars)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  localparam int Depth = 2 * LineChars;

  logic [7:0]       mem [Depth];
  logic [Depth-1:0] valid_r;
  logic [7:0]       rd_data_r;

  // Write port; valid bit marks entries that no longer hold the banner
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read, with forwarding of a same-cycle write
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else if (valid_r[rd_addr]) begin
      rd_data_r <= mem[rd_addr];
    end else begin
      rd_data_r <= clcd_pkg::banner_char(int'(rd_addr), LineChars);
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/clcd_seq.sv -----
module clcd_seq #(
  parameter int LineChars = clcd_pkg::LINE_CHARS,
  parameter int AddrW     = $clog2(2 * LineChars)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clcd_pkg::cfg_t       cfg,
  input  clcd_pkg::in_item_t   item,
  input  logic                 fire,
  input  logic [7:0]           rd_data,
  output clcd_pkg::out_item_t  result,
  output logic                 wr_en,
  output logic [AddrW-1:0]     wr_addr,
  output logic [7:0]           wr_data,
  output logic [AddrW-1:0]     rd_addr
);

  localparam int CharW = $clog2(LineChars);
  localparam logic [CharW:0]   LcW  = (CharW + 1)'(LineChars);
  localparam logic [AddrW-1:0] LcA  = AddrW'(LineChars);

  clcd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       wait_cnt_r, wait_cnt_nxt;
  logic [7:0]       refresh_cnt_r, refresh_cnt_nxt;
  logic [CharW-1:0] char_idx_r, char_idx_nxt;

  logic             tick;
  logic [CharW-1:0] idx_cur;
  logic [CharW-1:0] idx_nxt;
  logic [CharW:0]   idx_inc;

  assign tick = fire && (item.func == clcd_pkg::FUNC_TICK);

  // Clamp a stray index back to column 0
  assign idx_cur = ({1'b0, char_idx_r} < LcW) ? char_idx_r : '0;
  assign idx_nxt = ({1'b0, char_idx_nxt} < LcW) ? char_idx_nxt : '0;
  assign idx_inc = {1'b0, idx_cur} + (CharW + 1)'(1);

  // Next state
  always_comb begin
    phase_nxt       = phase_r;
    wait_cnt_nxt    = wait_cnt_r;
    refresh_cnt_nxt = refresh_cnt_r;
    char_idx_nxt    = char_idx_r;
    if (tick) begin
      case (phase_r)
        clcd_pkg::PH_POWER_UP: begin
          if (clcd_pkg::wait_done(wait_cnt_r, cfg.power_up_wait)) begin
            phase_nxt    = clcd_pkg::PH_RESET_WAIT;
            wait_cnt_nxt = '0;
          end else begin
            wait_cnt_nxt = clcd_pkg::bump(wait_cnt_r);
          end
        end
        clcd_pkg::PH_RESET_WAIT: begin
          if (clcd_pkg::wait_done(wait_cnt_r, cfg.reset_wait)) begin
            phase_nxt = clcd_pkg::PH_FUNC_3;
          end else begin
            wait_cnt_nxt = clcd_pkg::bump(wait_cnt_r);
          end
        end
        clcd_pkg::PH_FUNC_3:     phase_nxt = clcd_pkg::PH_FUNC_LINES;
        clcd_pkg::PH_FUNC_LINES: phase_nxt = clcd_pkg::PH_DISP_OFF;
        clcd_pkg::PH_DISP_OFF: begin
          if (!item.busy_flag) phase_nxt = clcd_pkg::PH_CLEAR;
        end
        clcd_pkg::PH_CLEAR: begin
          if (!item.busy_flag) begin
            phase_nxt    = clcd_pkg::PH_ENTRY;
            wait_cnt_nxt = '0;
          end
        end
        clcd_pkg::PH_ENTRY: begin
          if (clcd_pkg::wait_done(wait_cnt_r, cfg.clear_wait)) begin
            if (!item.busy_flag) begin
              phase_nxt    = clcd_pkg::PH_DISP_ON;
              wait_cnt_nxt = '0;
            end
          end else begin
            wait_cnt_nxt = clcd_pkg::bump(wait_cnt_r);
          end
        end
        clcd_pkg::PH_DISP_ON: begin
          if (!item.busy_flag) begin
            phase_nxt       = clcd_pkg::PH_IDLE;
            refresh_cnt_nxt = '0;
          end
        end
        clcd_pkg::PH_IDLE: begin
          if (!item.busy_flag) begin
            if (clcd_pkg::wait_done(refresh_cnt_r, cfg.refresh_wait)) begin
              phase_nxt       = clcd_pkg::PH_HOME;
              char_idx_nxt    = '0;
              refresh_cnt_nxt = '0;
            end else begin
              refresh_cnt_nxt = clcd_pkg::bump(refresh_cnt_r);
            end
          end
        end
        clcd_pkg::PH_HOME: begin
          if (!item.busy_flag) phase_nxt = clcd_pkg::PH_LINE1;
        end
        clcd_pkg::PH_DDRAM: begin
          if (!item.busy_flag) phase_nxt = clcd_pkg::PH_LINE2;
        end
        clcd_pkg::PH_LINE1, clcd_pkg::PH_LINE2: begin
          if (!item.busy_flag) begin
            if (idx_inc >= LcW) begin
              phase_nxt       = (phase_r == clcd_pkg::PH_LINE2) ?
                                clcd_pkg::PH_IDLE : clcd_pkg::PH_DDRAM;
              char_idx_nxt    = '0;
              refresh_cnt_nxt = '0;
            end else begin
              char_idx_nxt = idx_inc[CharW-1:0];
            end
          end
        end
        default: phase_nxt = clcd_pkg::PH_POWER_UP;
      endcase
    end
  end

  // Result of the current request
  always_comb begin
    result = '0;
    if (item.func == clcd_pkg::FUNC_TICK) begin
      case (phase_r)
        clcd_pkg::PH_POWER_UP: begin
          if (clcd_pkg::wait_done(wait_cnt_r, cfg.power_up_wait)) begin
            result.bus_write = 1'b1;
            result.bus_byte  = clcd_pkg::CMD_FUNC_SET;
          end
        end
        clcd_pkg::PH_RESET_WAIT: begin
          if (clcd_pkg::wait_done(wait_cnt_r, cfg.reset_wait)) begin
            result.bus_write = 1'b1;
            result.bus_byte  = clcd_pkg::CMD_FUNC_SET;
          end
        end
        clcd_pkg::PH_FUNC_3: begin
          result.bus_write = 1'b1;
          result.bus_byte  = clcd_pkg::CMD_FUNC_SET;
        end
        clcd_pkg::PH_FUNC_LINES: begin
          result.bus_write = 1'b1;
          result.bus_byte  = clcd_pkg::CMD_FUNC_2LINE;
        end
        clcd_pkg::PH_DISP_OFF: begin
          if (!item.busy_flag) begin
            result.bus_write = 1'b1;
            result.bus_byte  = clcd_pkg::CMD_DISP_OFF;
          end
        end
        clcd_pkg::PH_CLEAR: begin
          if (!item.busy_flag) begin
            result.bus_write = 1'b1;
            result.bus_byte  = clcd_pkg::CMD_CLEAR;
          end
        end
        clcd_pkg::PH_ENTRY: begin
          if (clcd_pkg::wait_done(wait_cnt_r, cfg.clear_wait) && !item.busy_flag) begin
            result.bus_write = 1'b1;
            result.bus_byte  = clcd_pkg::CMD_ENTRY;
          end
        end
        // resent on every tick until the panel reports not busy
        clcd_pkg::PH_DISP_ON: begin
          result.bus_write = 1'b1;
          result.bus_byte  = clcd_pkg::CMD_DISP_ON;
        end
        clcd_pkg::PH_IDLE: result.refresh_idle = 1'b1;
        clcd_pkg::PH_HOME: begin
          if (!item.busy_flag) begin
            result.bus_write = 1'b1;
            result.bus_byte  = clcd_pkg::CMD_HOME;
          end
        end
        clcd_pkg::PH_DDRAM: begin
          if (!item.busy_flag) begin
            result.bus_write = 1'b1;
            result.bus_byte  = clcd_pkg::CMD_DDRAM_L2;
          end
        end
        clcd_pkg::PH_LINE1, clcd_pkg::PH_LINE2: begin
          if (!item.busy_flag) begin
            result.bus_write  = 1'b1;
            result.reg_select = 1'b1;
            result.bus_byte   = rd_data;
          end
        end
        default: result = '0;
      endcase
    end
  end

  // Line store write from a character request
  assign wr_en   = fire && (item.func == clcd_pkg::FUNC_WRITE) &&
                   (int'(item.char_column) < LineChars);
  assign wr_addr = item.char_line ? (LcA + AddrW'(item.char_column)) :
                                    AddrW'(item.char_column);
  assign wr_data = item.char_code;

  // Prefetch the character the next line-phase tick will send
  assign rd_addr = ((phase_nxt == clcd_pkg::PH_LINE2) ? LcA : '0) + AddrW'(idx_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= clcd_pkg::PH_POWER_UP;
      wait_cnt_r    <= '0;
      refresh_cnt_r <= '0;
      char_idx_r    <= '0;
    end else begin
      phase_r       <= phase_nxt;
      wait_cnt_r    <= wait_cnt_nxt;
      refresh_cnt_r <= refresh_cnt_nxt;
      char_idx_r    <= char_idx_nxt;
    end
  end

endmodule

// ----- rtl/char_lcd_init_refresh_controller_top.sv -----
// Channel  Dir  Handshake           Payload
// in_      in   tvalid/tready       tuser: func; tdata: busy, line, column, code
// out_     out  tvalid/tready       tuser: reg_select; tdata: write, byte, idle
// cfg_     in   APB, pready high    four 8-bit wait registers at 0x0/0x4/0x8/0xC
//
// One request per clock while the output is not stalled: input register, one
// pass of sequencer logic, result register. The line store read address is
// taken from the next state, so the registered read data is ready ahead of use.
// Reset (rst_n low, synchronous) clears control state and line store valid
// bits; unwritten entries read back as the banner text.
// A stalled result register holds; the input register keeps taking requests
// until both stages are full.
`include "char_lcd_init_refresh_controller_top_macros.svh"

module char_lcd_init_refresh_controller_top #(
  parameter int LINE_CHARS = clcd_pkg::LINE_CHARS
) (
  input  logic        clk,
  input  logic        rst_n,
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] busy_flag, [1] char_line, [5:2] char_column,
                                  // [13:6] char_code, [15:14] zero
  input  logic [0:0]  in_tuser,   // [0] func
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] bus_write, [8:1] bus_byte, [9] refresh_idle,
                                  // [15:10] zero
  output logic [0:0]  out_tuser,  // [0] reg_select
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AddrW = $clog2(2 * LINE_CHARS);

  clcd_pkg::cfg_t      cfg_r;
  clcd_pkg::in_item_t  s1_item_r;
  logic                s1_valid_r;
  logic                s1_fire;
  clcd_pkg::out_item_t result;
  clcd_pkg::out_item_t out_item_r;
  logic                out_valid_r;

  logic                st_wr_en;
  logic [AddrW-1:0]    st_wr_addr;
  logic [7:0]          st_wr_data;
  logic [AddrW-1:0]    st_rd_addr;
  logic [7:0]          st_rd_data;
  logic                cfg_wr;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_up_wait <= clcd_pkg::POWER_UP_WAIT_RST;
      cfg_r.reset_wait    <= clcd_pkg::RESET_WAIT_RST;
      cfg_r.clear_wait    <= clcd_pkg::CLEAR_WAIT_RST;
      cfg_r.refresh_wait  <= clcd_pkg::REFRESH_WAIT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        clcd_pkg::REG_POWER_UP_WAIT: cfg_r.power_up_wait <= cfg_pwdata[7:0];
        clcd_pkg::REG_RESET_WAIT:    cfg_r.reset_wait    <= cfg_pwdata[7:0];
        clcd_pkg::REG_CLEAR_WAIT:    cfg_r.clear_wait    <= cfg_pwdata[7:0];
        clcd_pkg::REG_REFRESH_WAIT:  cfg_r.refresh_wait  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_paddr[3:2])
      clcd_pkg::REG_POWER_UP_WAIT: cfg_prdata = {24'd0, cfg_r.power_up_wait};
      clcd_pkg::REG_RESET_WAIT:    cfg_prdata = {24'd0, cfg_r.reset_wait};
      clcd_pkg::REG_CLEAR_WAIT:    cfg_prdata = {24'd0, cfg_r.clear_wait};
      clcd_pkg::REG_REFRESH_WAIT:  cfg_prdata = {24'd0, cfg_r.refresh_wait};
      default:                     cfg_prdata = '0;
    endcase
  end

  // Input register
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!s1_valid_r || s1_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.func        <= in_tuser[0];
      s1_item_r.busy_flag   <= in_tdata[0];
      s1_item_r.char_line   <= in_tdata[1];
      s1_item_r.char_column <= in_tdata[5:2];
      s1_item_r.char_code   <= in_tdata[13:6];
    end
  end

  clcd_seq #(
    .LineChars (LINE_CHARS),
    .AddrW     (AddrW)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .item    (s1_item_r),
    .fire    (s1_fire),
    .rd_data (st_rd_data),
    .result  (result),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (st_rd_addr)
  );

  clcd_line_store #(
    .LineChars (LINE_CHARS),
    .AddrW     (AddrW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_item_r.reg_select;
  assign out_tdata  = {6'd0, out_item_r.refresh_idle, out_item_r.bus_byte,
                       out_item_r.bus_write};

  // Checks
  `CLCD_NEVER(a_rs_without_write, out_tvalid && out_tuser[0] && !out_tdata[0], "data select without bus write")
  `CLCD_NEVER(a_idle_with_write, out_tvalid && out_tdata[9] && out_tdata[0], "bus write during idle tick")
  `CLCD_ASSERT(a_quiet_byte_zero, (out_tvalid && !out_tdata[0]) |-> (out_tdata[8:1] == 8'd0), "nonzero byte without write")
  `CLCD_ASSERT(a_no_store_write_on_tick, (st_wr_en |-> (s1_item_r.func == clcd_pkg::FUNC_WRITE)), "line store written by a tick")

endmodule
